@@ src/mpfu_pkg.sv @@
// Shared types, codes and modular helper functions for the prime field unit.
// Used by mpfu_regs, the field unit top and the testbench; depends on nothing.
`default_nettype none
package mpfu_pkg;

  localparam int ModWidth = 32;
  localparam int CntWidth = 7;

  localparam logic [2:0] FuncMul      = 3'd0;
  localparam logic [2:0] FuncToMont   = 3'd1;
  localparam logic [2:0] FuncFromMont = 3'd2;
  localparam logic [2:0] FuncInverse  = 3'd3;
  localparam logic [2:0] FuncPartInv  = 3'd4;

  localparam int AddrWidth = 4;
  localparam logic [AddrWidth-1:0] AddrPrime  = 4'h0;
  localparam logic [AddrWidth-1:0] AddrNegInv = 4'h8;

  localparam logic [ModWidth-1:0] PrimeReset  = 32'd883949569;
  localparam logic [63:0]         NegInvReset = 64'd2677397675937103871;

  typedef struct packed {
    logic [2:0]          func;
    logic [ModWidth-1:0] operand_a;
    logic [ModWidth-1:0] operand_b;
    logic signed [63:0]  plain_value;
  } in_item_t;

  typedef struct packed {
    logic [ModWidth-1:0] result;
    logic [CntWidth-1:0] step_count;
    logic                not_invertible;
  } out_item_t;

  // (2*r + b) mod p for r < p
  function automatic logic [ModWidth-1:0] mod_dbl(logic [ModWidth-1:0] r, logic b,
                                                  logic [ModWidth-1:0] p);
    logic [ModWidth:0] t;
    t = {r, b};
    if (t >= {1'b0, p}) begin
      t = t - {1'b0, p};
    end
    return t[ModWidth-1:0];
  endfunction

  // (x + y) mod p for x, y < p
  function automatic logic [ModWidth-1:0] mod_add(logic [ModWidth-1:0] x,
                                                  logic [ModWidth-1:0] y,
                                                  logic [ModWidth-1:0] p);
    logic [ModWidth:0] t;
    t = {1'b0, x} + {1'b0, y};
    if (t >= {1'b0, p}) begin
      t = t - {1'b0, p};
    end
    return t[ModWidth-1:0];
  endfunction

  function automatic logic [ModWidth-1:0] half_mod(logic [ModWidth-1:0] x,
                                                   logic [ModWidth-1:0] p);
    logic [ModWidth:0] t;
    t = x[0] ? ({1'b0, x} + {1'b0, p}) : {1'b0, x};
    return t[ModWidth:1];
  endfunction

  function automatic logic [ModWidth-1:0] sub_mod(logic [ModWidth-1:0] x,
                                                  logic [ModWidth-1:0] y,
                                                  logic [ModWidth-1:0] p);
    return (x >= y) ? (x - y) : (x + p - y);
  endfunction

endpackage
`default_nettype wire

@@ src/montgomery_prime_field_unit.sv @@
// Montgomery prime field unit (R = 2^64): multiply, conversions, full and partial inverse.
// Depends on mpfu_pkg, mpfu_mul and mpfu_regs.
//
// One item is worked at a time; the input stalls until the item's result is in the
// output register, which then waits for transfer while the next item may start.
// Montgomery multiply and from-Montgomery each run three products through the single
// serial shift-add multiplier. To-Montgomery works by one-bit modular reduction and
// double-and-add. The full inverse takes one reduction, a binary Euclid loop of
// subtraction rounds and halvings, and a to-Montgomery pass. The partial inverse
// runs as a loop of iterations. Unused function codes go straight to the done state.
`default_nettype none
module montgomery_prime_field_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire mpfu_pkg::in_item_t            in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output mpfu_pkg::out_item_t                out_data_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [mpfu_pkg::AddrWidth-1:0] paddr,
  input  wire logic [63:0]                   pwdata,
  output logic [63:0]                        prdata,
  output logic                               pready
);
  import mpfu_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE    = 13'b0000000000001,
    S_MUL_AB  = 13'b0000000000010,
    S_MUL_W   = 13'b0000000000100,
    S_MUL_WP  = 13'b0000000001000,
    S_INV_CHK = 13'b0000000010000,
    S_INV_HU  = 13'b0000000100000,
    S_INV_HV  = 13'b0000001000000,
    S_INV_SUB = 13'b0000010000000,
    S_TM_RED  = 13'b0000100000000,
    S_TM_R2   = 13'b0001000000000,
    S_TM_MUL  = 13'b0010000000000,
    S_PI_LOOP = 13'b0100000000000,
    S_DONE    = 13'b1000000000000
  } state_e;

  localparam logic [ModWidth-1:0] One = {{(ModWidth-1){1'b0}}, 1'b1};

  state_e state_q, state_d;

  logic [ModWidth-1:0] prime;
  logic [63:0]         neg_inv;

  logic                mul_start, mul_busy, mul_done;
  logic [63:0]         mul_x, mul_y;
  logic [127:0]        mul_prod;

  logic [2:0]          func_q, func_d;
  logic [63:0]         p1_q, p1_d;
  logic [ModWidth-1:0] u_q, u_d, v_q, v_d, x1_q, x1_d, x2_q, x2_d;
  logic [ModWidth-1:0] r_q, r_d, km_q, km_d, acc_q, acc_d;
  logic [63:0]         k_q, k_d, pr_q, pr_d, ps_q, ps_d;
  logic                neg_q, neg_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  out_item_t           fin_q, fin_d, out_q;
  logic                out_valid_q;

  logic                in_xfer, out_free;
  logic [64:0]         redc_lo;
  logic [63:0]         redc_z;
  logic [ModWidth-1:0] redc_res, r_next, r_one, a_next, u_sub, v_sub;
  logic [63:0]         pv_abs;

  mpfu_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .prime_o   (prime),
    .neg_inv_o (neg_inv)
  );

  mpfu_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .x_i     (mul_x),
    .y_i     (mul_y),
    .busy_o  (mul_busy),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign redc_lo  = {1'b0, p1_q} + {1'b0, mul_prod[63:0]};
  assign redc_z   = mul_prod[127:64] + {63'd0, redc_lo[64]};
  assign redc_res = (redc_z >= {{(64-ModWidth){1'b0}}, prime}) ?
                    redc_z[ModWidth-1:0] - prime : redc_z[ModWidth-1:0];
  assign pv_abs   = in_data_i.plain_value[63] ? (64'd0 - in_data_i.plain_value)
                                              : in_data_i.plain_value;
  assign r_next   = mod_dbl(r_q, k_q[63], prime);
  assign r_one    = (prime == One) ? '0 : One;
  assign a_next   = k_q[63] ? mod_add(mod_dbl(acc_q, 1'b0, prime), km_q, prime)
                            : mod_dbl(acc_q, 1'b0, prime);
  assign u_sub    = u_q - v_q;
  assign v_sub    = v_q - u_q;

  always_comb begin
    mul_start = 1'b0;
    mul_x     = {{(64-ModWidth){1'b0}}, in_data_i.operand_a};
    mul_y     = {{(64-ModWidth){1'b0}}, in_data_i.operand_b};
    case (state_q)
      S_IDLE: begin
        if (in_data_i.func == FuncFromMont || in_data_i.func == FuncInverse) begin
          mul_y = 64'd1;
        end
        mul_start = in_xfer && (in_data_i.func == FuncMul ||
                                in_data_i.func == FuncFromMont ||
                                in_data_i.func == FuncInverse);
      end
      S_MUL_AB: begin
        mul_x     = mul_prod[63:0];
        mul_y     = neg_inv;
        mul_start = mul_done;
      end
      S_MUL_W: begin
        mul_x     = mul_prod[63:0];
        mul_y     = {{(64-ModWidth){1'b0}}, prime};
        mul_start = mul_done;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    func_d  = func_q;
    p1_d    = p1_q;
    u_d     = u_q;
    v_d     = v_q;
    x1_d    = x1_q;
    x2_d    = x2_q;
    r_d     = r_q;
    km_d    = km_q;
    acc_d   = acc_q;
    k_d     = k_q;
    pr_d    = pr_q;
    ps_d    = ps_q;
    neg_d   = neg_q;
    cnt_d   = cnt_q;
    fin_d   = fin_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          func_d = in_data_i.func;
          fin_d  = '0;
          cnt_d  = '0;
          case (in_data_i.func)
            FuncMul, FuncFromMont, FuncInverse: state_d = S_MUL_AB;
            FuncToMont: begin
              k_d   = pv_abs;
              neg_d = in_data_i.plain_value[63];
              r_d   = '0;
              state_d = (prime == '0) ? S_DONE : S_TM_RED;
            end
            FuncPartInv: begin
              u_d  = in_data_i.operand_a;
              v_d  = prime;
              pr_d = 64'd1;
              ps_d = '0;
              state_d = S_PI_LOOP;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_MUL_AB: begin
        if (mul_done) begin
          p1_d    = mul_prod[63:0];
          state_d = S_MUL_W;
        end
      end
      S_MUL_W: begin
        if (mul_done) begin
          state_d = S_MUL_WP;
        end
      end
      S_MUL_WP: begin
        if (mul_done) begin
          if (func_q == FuncInverse) begin
            if (prime == '0 || redc_res == '0) begin
              fin_d.not_invertible = 1'b1;
              state_d = S_DONE;
            end else begin
              u_d  = redc_res;
              v_d  = prime;
              x1_d = r_one;
              x2_d = '0;
              state_d = S_INV_CHK;
            end
          end else begin
            fin_d.result = redc_res;
            state_d = S_DONE;
          end
        end
      end
      S_INV_CHK: begin
        if (u_q == One || v_q == One) begin
          k_d   = {{(64-ModWidth){1'b0}}, (u_q == One) ? x1_q : x2_q};
          neg_d = 1'b0;
          r_d   = '0;
          cnt_d = '0;
          state_d = S_TM_RED;
        end else begin
          state_d = S_INV_HU;
        end
      end
      S_INV_HU: begin
        if (!u_q[0]) begin
          u_d  = u_q >> 1;
          x1_d = half_mod(x1_q, prime);
        end else begin
          state_d = S_INV_HV;
        end
      end
      S_INV_HV: begin
        if (!v_q[0]) begin
          v_d  = v_q >> 1;
          x2_d = half_mod(x2_q, prime);
        end else begin
          state_d = S_INV_SUB;
        end
      end
      S_INV_SUB: begin
        if (u_q >= v_q) begin
          u_d  = u_sub;
          x1_d = sub_mod(x1_q, x2_q, prime);
        end else begin
          v_d  = v_sub;
          x2_d = sub_mod(x2_q, x1_q, prime);
        end
        if ((u_q >= v_q && u_sub == '0) || (u_q < v_q && v_sub == '0)) begin
          fin_d.not_invertible = 1'b1;
          state_d = S_DONE;
        end else begin
          state_d = S_INV_CHK;
        end
      end
      S_TM_RED: begin
        r_d   = r_next;
        k_d   = k_q << 1;
        cnt_d = cnt_q + CntWidth'(1);
        if (cnt_q == CntWidth'(63)) begin
          km_d  = (neg_q && r_next != '0) ? prime - r_next :
                  (neg_q ? '0 : r_next);
          r_d   = r_one;
          cnt_d = '0;
          state_d = S_TM_R2;
        end
      end
      S_TM_R2: begin
        r_d   = mod_dbl(r_q, 1'b0, prime);
        cnt_d = cnt_q + CntWidth'(1);
        if (cnt_q == CntWidth'(63)) begin
          k_d   = {mod_dbl(r_q, 1'b0, prime), {(64-ModWidth){1'b0}}};
          acc_d = '0;
          cnt_d = '0;
          state_d = S_TM_MUL;
        end
      end
      S_TM_MUL: begin
        acc_d = a_next;
        k_d   = k_q << 1;
        cnt_d = cnt_q + CntWidth'(1);
        if (cnt_q == CntWidth'(ModWidth - 1)) begin
          fin_d.result = a_next;
          state_d = S_DONE;
        end
      end
      S_PI_LOOP: begin
        if (v_q == '0) begin
          if (u_q != One) begin
            fin_d.not_invertible = 1'b1;
          end else begin
            pr_d = (pr_q >= {{(64-ModWidth){1'b0}}, prime}) ?
                   pr_q - {{(64-ModWidth){1'b0}}, prime} : pr_q;
            fin_d.result     = pr_d[ModWidth-1:0];
            fin_d.step_count = cnt_q;
          end
          state_d = S_DONE;
        end else if (u_q == '0) begin
          fin_d.not_invertible = 1'b1;
          state_d = S_DONE;
        end else begin
          cnt_d = cnt_q + CntWidth'(1);
          if (!v_q[0]) begin
            v_d  = v_q >> 1;
            pr_d = pr_q << 1;
          end else if (!u_q[0]) begin
            u_d  = u_q >> 1;
            ps_d = ps_q << 1;
          end else if (v_q >= u_q) begin
            v_d  = v_sub >> 1;
            ps_d = ps_q + pr_q;
            pr_d = pr_q << 1;
          end else begin
            u_d  = u_sub >> 1;
            pr_d = pr_q + ps_q;
            ps_d = ps_q << 1;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    func_q <= func_d;
    p1_q   <= p1_d;
    u_q    <= u_d;
    v_q    <= v_d;
    x1_q   <= x1_d;
    x2_q   <= x2_d;
    r_q    <= r_d;
    km_q   <= km_d;
    acc_q  <= acc_d;
    k_q    <= k_d;
    pr_q   <= pr_d;
    ps_q   <= ps_d;
    neg_q  <= neg_d;
    fin_q  <= fin_d;
    if (state_q == S_DONE && out_free) begin
      out_q <= fin_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_onehot_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state register not one-hot");

  a_mul_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start |-> !mul_busy) else $error("multiplier restarted while busy");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q != S_IDLE) else $error("accepted item not started");

  a_flag_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.not_invertible |-> out_q.result == '0 && out_q.step_count == '0)
    else $error("not-invertible result carries data");

  a_done_loads_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE && out_free |=> out_valid_q) else $error("result not presented");

endmodule
`default_nettype wire

@@ src/mpfu_mul.sv @@
// Serial 64x64 shift-add multiplier, one multiplier bit per cycle.
// Depends on nothing; a single instance serves every Montgomery product of the field unit.
`default_nettype none
module mpfu_mul (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [63:0]  x_i,
  input  wire logic [63:0]  y_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [127:0]      prod_o
);

  logic [63:0] x_q, y_q, hi_q, lo_q, hi_d;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q;
  logic [64:0] sum;

  assign sum  = {1'b0, hi_q} + (y_q[0] ? {1'b0, x_q} : 65'd0);
  assign hi_d = sum[64:1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q  <= x_i;
      y_q  <= y_i;
      hi_q <= '0;
      lo_q <= '0;
    end else if (busy_q) begin
      hi_q <= hi_d;
      lo_q <= {sum[0], lo_q[63:1]};
      y_q  <= {1'b0, y_q[63:1]};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign prod_o = {hi_q, lo_q};

endmodule
`default_nettype wire

@@ src/mpfu_regs.sv @@
// APB register file holding the prime modulus and minus its inverse mod 2^64.
// Depends on mpfu_pkg.
`default_nettype none
module mpfu_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [mpfu_pkg::AddrWidth-1:0] paddr,
  input  wire logic [63:0]                   pwdata,
  output logic [63:0]                        prdata,
  output logic                               pready,
  output logic [mpfu_pkg::ModWidth-1:0]      prime_o,
  output logic [63:0]                        neg_inv_o
);
  import mpfu_pkg::*;

  logic [ModWidth-1:0] prime_q;
  logic [63:0]         neg_inv_q;
  logic                wr_en;

  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prime_q   <= PrimeReset;
      neg_inv_q <= NegInvReset;
    end else if (wr_en) begin
      if (paddr == AddrPrime) begin
        prime_q <= pwdata[ModWidth-1:0];
      end else if (paddr == AddrNegInv) begin
        neg_inv_q <= pwdata;
      end
    end
  end

  always_comb begin
    case (paddr)
      AddrPrime:  prdata = {{(64-ModWidth){1'b0}}, prime_q};
      AddrNegInv: prdata = neg_inv_q;
      default:    prdata = '0;
    endcase
  end

  assign pready    = 1'b1;
  assign prime_o   = prime_q;
  assign neg_inv_o = neg_inv_q;

endmodule
`default_nettype wire

@@ tb/mpfu_checker.sv @@
// Checker for the Montgomery prime field unit: watches the item channels and the
// register port, predicts each result and compares it. Depends on mpfu_pkg.
module mpfu_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  mpfu_pkg::in_item_t            in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  mpfu_pkg::out_item_t           out_data_i,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic                          pready_i,
  input  logic [mpfu_pkg::AddrWidth-1:0] paddr_i,
  input  logic [63:0]                   pwdata_i,
  output int                            fail_count_o,
  output int                            pending_o
);
  import mpfu_pkg::*;

  bit [63:0] prime_q;
  bit [63:0] neg_inv_q;
  out_item_t expected_q[$];

  function automatic bit [63:0] mont_reduce(bit [63:0] x, bit [63:0] y);
    bit [127:0] prod, t;
    bit [63:0] xl, xh, w, lo, z;
    prod = {64'd0, x} * {64'd0, y};
    xl = prod[63:0];
    xh = prod[127:64];
    w = xl * neg_inv_q;
    t = {64'd0, w} * {64'd0, prime_q};
    lo = xl + t[63:0];
    z = xh + t[127:64] + ((lo < xl) ? 64'd1 : 64'd0);
    if (z >= prime_q) z = z - prime_q;
    return {32'd0, z[31:0]};
  endfunction

  function automatic bit [63:0] to_mont_form(bit [63:0] k);
    bit [63:0] p, m, km, rm;
    bit [127:0] q;
    p = prime_q;
    if (p == 0) return 0;
    if (k[63]) begin
      m = (64'd0 - k) % p;
      km = (m != 0) ? p - m : 0;
    end else begin
      km = k % p;
    end
    rm = ((64'hFFFF_FFFF_FFFF_FFFF % p) + 1) % p;
    q = ({64'd0, km} * {64'd0, rm}) % {64'd0, p};
    return {32'd0, q[31:0]};
  endfunction

  function automatic bit [63:0] halve(bit [63:0] x);
    return x[0] ? (x + prime_q) >> 1 : x >> 1;
  endfunction

  function automatic bit [63:0] sub_field(bit [63:0] x, bit [63:0] y);
    return (x >= y) ? x - y : x + prime_q - y;
  endfunction

  function automatic out_item_t field_inverse(bit [63:0] a);
    out_item_t r;
    bit [63:0] u, v, x1, x2;
    r = '0;
    r.not_invertible = 1'b1;
    u = mont_reduce(a, 1);
    v = prime_q;
    x1 = 1;
    x2 = 0;
    if (prime_q == 0 || u == 0) return r;
    if (x1 >= prime_q) x1 = 0;
    while (u != 1 && v != 1) begin
      while (u[0] == 1'b0) begin
        u = u >> 1;
        x1 = halve(x1);
      end
      while (v[0] == 1'b0) begin
        v = v >> 1;
        x2 = halve(x2);
      end
      if (u >= v) begin
        u = u - v;
        x1 = sub_field(x1, x2);
      end else begin
        v = v - u;
        x2 = sub_field(x2, x1);
      end
      if (u == 0 || v == 0) return r;
    end
    r.result = to_mont_form((u == 1) ? x1 : x2);
    r.not_invertible = 1'b0;
    return r;
  endfunction

  function automatic out_item_t kaliski_inverse(bit [63:0] a);
    out_item_t r;
    bit [63:0] u, v, s, rr, k;
    r = '0;
    r.not_invertible = 1'b1;
    u = a;
    v = prime_q;
    s = 0;
    rr = 1;
    k = 0;
    while (v > 0) begin
      if (u == 0) return r;
      if (v[0] == 1'b0) begin
        v = v >> 1;
        rr = rr << 1;
      end else if (u[0] == 1'b0) begin
        u = u >> 1;
        s = s << 1;
      end else if (v >= u) begin
        v = (v - u) >> 1;
        s = s + rr;
        rr = rr << 1;
      end else begin
        u = (u - v) >> 1;
        rr = rr + s;
        s = s << 1;
      end
      k++;
    end
    if (u != 1) return r;
    if (rr >= prime_q) rr = rr - prime_q;
    r.result = rr[31:0];
    r.step_count = k[6:0];
    r.not_invertible = 1'b0;
    return r;
  endfunction

  function automatic out_item_t predict_field_op(in_item_t it);
    out_item_t r;
    r = '0;
    case (it.func)
      FuncMul:      r.result = mont_reduce({32'd0, it.operand_a}, {32'd0, it.operand_b});
      FuncToMont:   r.result = to_mont_form(it.plain_value);
      FuncFromMont: r.result = mont_reduce({32'd0, it.operand_a}, 1);
      FuncInverse:  r = field_inverse({32'd0, it.operand_a});
      FuncPartInv:  r = kaliski_inverse({32'd0, it.operand_a});
      default:      r = '0;
    endcase
    return r;
  endfunction

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_item;
    int errs;
    errs = 0;
    if (!rst_ni) begin
      prime_q <= {32'd0, PrimeReset};
      neg_inv_q <= NegInvReset;
      expected_q.delete();
      fail_count_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i == AddrPrime) prime_q <= {32'd0, pwdata_i[31:0]};
        else if (paddr_i == AddrNegInv) neg_inv_q <= pwdata_i;
      end
      if (in_valid_i && !in_stall_i) expected_q.push_back(predict_field_op(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("result transfer with no item outstanding");
          errs++;
        end else begin
          exp_item = expected_q.pop_front();
          if (exp_item.result !== out_data_i.result) begin
            $error("result: expected %0h, got %0h", exp_item.result, out_data_i.result);
            errs++;
          end
          if (exp_item.step_count !== out_data_i.step_count) begin
            $error("step_count: expected %0d, got %0d", exp_item.step_count,
                   out_data_i.step_count);
            errs++;
          end
          if (exp_item.not_invertible !== out_data_i.not_invertible) begin
            $error("not_invertible: expected %0b, got %0b", exp_item.not_invertible,
                   out_data_i.not_invertible);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count_o <= fail_count_o + errs;
    end
  end

endmodule

@@ tb/tb_montgomery_prime_field_unit.sv @@
// Testbench top for the Montgomery prime field unit: clock, reset, register writes, item
// stimulus with idle and stall phases, verdict. Depends on mpfu_pkg, mpfu_checker, DUT.
module tb_montgomery_prime_field_unit;
  import mpfu_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AddrWidth-1:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  int fail_count;
  int pending;
  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_req = 1'b0;
  bit hold_taken = 1'b0;
  int hold_cnt = 0;
  int quiet_cycles = 0;
  bit [31:0] cur_prime = PrimeReset;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  montgomery_prime_field_unit u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  mpfu_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .pready_i(pready),
    .paddr_i(paddr), .pwdata_i(pwdata),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      out_stall <= 1'b1;
      hold_cnt <= hold_cnt - 1;
    end else if (hold_req && !hold_taken) begin
      out_stall <= 1'b1;
      hold_cnt <= 400;
      hold_taken <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= 30000) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_item(input in_item_t it);
    int gap;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_op(input logic [2:0] f, input logic [31:0] a, input logic [31:0] b,
                         input logic [63:0] k);
    in_item_t it;
    it.func = f;
    it.operand_a = a;
    it.operand_b = b;
    it.plain_value = k;
    send_item(it);
  endtask

  task automatic write_reg(input logic [AddrWidth-1:0] addr, input logic [63:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  function automatic logic [63:0] neg_inverse_of(logic [31:0] p);
    logic [63:0] inv;
    inv = {32'd0, p};
    repeat (6) inv = inv * (64'd2 - {32'd0, p} * inv);
    return 64'd0 - inv;
  endfunction

  task automatic set_field(input logic [31:0] p, input bit exact_inv);
    drain();
    write_reg(AddrPrime, {32'd0, p});
    write_reg(AddrNegInv, exact_inv ? neg_inverse_of(p) : {$urandom, $urandom});
    cur_prime = p;
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(9))
      0: return 32'd0;
      1: return 32'd1;
      2: return (cur_prime != 0) ? cur_prime - 32'd1 : 32'hFFFF_FFFF;
      3: return $urandom;
      default: return (cur_prime != 0) ? $urandom % cur_prime : $urandom;
    endcase
  endfunction

  function automatic logic [63:0] pick_plain();
    case ($urandom_range(7))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7FFF_FFFF_FFFF_FFFF;
      2: return 64'hFFFF_FFFF_FFFF_FFFF;
      3: return {32'd0, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic run_random(input int count);
    logic [2:0] f;
    repeat (count) begin
      f = ($urandom_range(19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(4));
      send_op(f, pick_operand(), pick_operand(), pick_plain());
    end
  endtask

  initial begin
    logic [31:0] primes[6];
    primes = '{32'd3, 32'd4294967291, 32'd4294967295, 32'd65537, 32'd2147483647,
               PrimeReset};
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_op(FuncMul, 32'd0, 32'd0, 64'd0);
    send_op(FuncMul, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'd0);
    send_op(FuncMul, PrimeReset - 1, PrimeReset - 1, 64'd0);
    send_op(FuncToMont, 32'd0, 32'd0, 64'd0);
    send_op(FuncToMont, 32'd0, 32'd0, 64'd1);
    send_op(FuncToMont, 32'd0, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_op(FuncToMont, 32'd0, 32'd0, 64'h8000_0000_0000_0000);
    send_op(FuncToMont, 32'd0, 32'd0, 64'h7FFF_FFFF_FFFF_FFFF);
    send_op(FuncFromMont, 32'd0, 32'd0, 64'd0);
    send_op(FuncFromMont, 32'hFFFF_FFFF, 32'd0, 64'd0);
    send_op(FuncInverse, 32'd0, 32'd0, 64'd0);
    send_op(FuncInverse, 32'd1, 32'd0, 64'd0);
    send_op(FuncInverse, PrimeReset - 1, 32'd0, 64'd0);
    send_op(FuncInverse, PrimeReset, 32'd0, 64'd0);
    send_op(FuncPartInv, 32'd0, 32'd0, 64'd0);
    send_op(FuncPartInv, 32'd1, 32'd0, 64'd0);
    send_op(FuncPartInv, PrimeReset - 1, 32'd0, 64'd0);
    send_op(FuncPartInv, 32'hFFFF_FFFF, 32'd0, 64'd0);
    send_op(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_op(3'd6, 32'd0, 32'd0, 64'd0);
    send_op(3'd7, 32'd1, 32'd1, 64'd1);

    set_field(32'd0, 1'b0);
    run_random(15);
    set_field(32'd4294967291, 1'b0);
    run_random(15);

    for (int i = 0; i < 6; i++) begin
      set_field(primes[i], 1'b1);
      case (i % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 70; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 70; end
        default: begin idle_pct = 8; stall_pct = 8; end
      endcase
      if (i == 4) begin
        idle_pct = 0;
        stall_pct = 0;
        hold_req = 1'b1;
      end
      run_random(90);
    end

    drain();
    repeat (600) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ montgomery_prime_field_unit.f @@
src/mpfu_pkg.sv
src/mpfu_mul.sv
src/mpfu_regs.sv
src/montgomery_prime_field_unit.sv
tb/mpfu_checker.sv
tb/tb_montgomery_prime_field_unit.sv
